FILE: rtl/core/csd_pkg.sv
// Shared types, constants and character tables for the session type detector.
`default_nettype none
package csd_pkg;

  localparam int MAX_WAKE_TRIES    = 20;
  localparam int MAX_INQUIRY_TRIES = 8;
  localparam int INTRO_WAIT_TICKS  = 4;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [7:0] CH_DC1 = 8'h11;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_STAR = 8'h2A;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DETECT = 3'd1;
  localparam logic [2:0] ST_FTSC   = 3'd2;
  localparam logic [2:0] ST_YOOHOO = 3'd3;
  localparam logic [2:0] ST_EMSI   = 3'd4;
  localparam logic [2:0] ST_FAIL   = 3'd5;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] REG_NO_EMSI     = 2'd0;
  localparam logic [1:0] REG_NO_WAZOO    = 2'd1;
  localparam logic [1:0] REG_YOOHOO_CODE = 2'd2;
  localparam logic [1:0] REG_TSYNC_CODE  = 2'd3;

  localparam logic [5:0] ANSWER_LEN = 6'd31;
  localparam logic [5:0] BURST_LEN  = 6'd29;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SKIP = 5'b00010,
    PH_WAKE = 5'b00100,
    PH_WAIT = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  // What the back end has to send for one transaction
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_CR     = 2'd1,
    CMD_INTRO  = 2'd2,
    CMD_ANSWER = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic       crc_mode;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       no_emsi;
    logic       no_wazoo;
    logic [7:0] yoohoo_code;
    logic [7:0] tsync_code;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [2:0] status;
    logic       crc;
  } entry_t;

  // Inquiry string: two stars, then the inquiry token
  function automatic logic [7:0] inq_char(input logic [3:0] j);
    logic [7:0] ch;
    case (j)
      4'd0, 4'd1: ch = "*";
      4'd2:       ch = "E";
      4'd3:       ch = "M";
      4'd4:       ch = "S";
      4'd5:       ch = "I";
      4'd6:       ch = "_";
      4'd7:       ch = "I";
      4'd8:       ch = "N";
      4'd9:       ch = "Q";
      4'd10:      ch = "C";
      4'd11:      ch = "8";
      4'd12:      ch = "1";
      4'd13:      ch = "6";
      default:    ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Request token expected after a star
  function automatic logic [7:0] req_char(input logic [3:0] j);
    logic [7:0] ch;
    case (j)
      4'd0:    ch = "E";
      4'd1:    ch = "M";
      4'd2:    ch = "S";
      4'd3:    ch = "I";
      4'd4:    ch = "_";
      4'd5:    ch = "R";
      4'd6:    ch = "E";
      4'd7:    ch = "Q";
      4'd8:    ch = "A";
      4'd9:    ch = "7";
      4'd10:   ch = "7";
      4'd11:   ch = "E";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  // CR then the inquiry twice
  function automatic logic [7:0] burst_byte(input logic [5:0] i);
    logic [7:0] ch;
    if (i == 6'd0) begin
      ch = CH_CR;
    end else if (i <= 6'd14) begin
      ch = inq_char(4'(i - 6'd1));
    end else begin
      ch = inq_char(4'(i - 6'd15));
    end
    return ch;
  endfunction

  // inquiry CR inquiry CR DC1
  function automatic logic [7:0] answer_byte(input logic [5:0] i);
    logic [7:0] ch;
    if (i <= 6'd13) begin
      ch = inq_char(4'(i));
    end else if (i == 6'd14 || i == 6'd29) begin
      ch = CH_CR;
    end else if (i == 6'd30) begin
      ch = CH_DC1;
    end else begin
      ch = inq_char(4'(i - 6'd15));
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/csd_front.sv
// Front end: accepts input transactions, runs the detection state and queues commands.
`default_nettype none
module csd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire csd_pkg::cfg_t  cfg,
  input  wire logic           take,
  input  wire csd_pkg::item_t item,
  output csd_pkg::entry_t     entry
);
  import csd_pkg::*;

  phase_t     phase, phase_next;
  logic [4:0] retry_count, retry_count_next;
  logic [2:0] wait_timer, wait_timer_next;
  logic [1:0] ftsc_hits, ftsc_hits_next;
  logic [7:0] yoohoo_hits, yoohoo_hits_next;
  logic       after_star, after_star_next;
  logic [3:0] match_position, match_position_next;
  logic       match_still_ok, match_still_ok_next;
  logic       crc_flag, crc_flag_next;
  logic [2:0] outcome, outcome_next;
  cmd_t       cmd;

  always_comb begin
    logic [7:0] c;
    logic [2:0] limit;
    logic [2:0] tick;
    logic       hit;
    c = item.rx_byte;
    phase_next          = phase;
    retry_count_next    = retry_count;
    wait_timer_next     = wait_timer;
    ftsc_hits_next      = ftsc_hits;
    yoohoo_hits_next    = yoohoo_hits;
    after_star_next     = after_star;
    match_position_next = match_position;
    match_still_ok_next = match_still_ok;
    crc_flag_next       = crc_flag;
    outcome_next        = outcome;
    cmd                 = CMD_NONE;
    hit                 = 1'b0;
    limit = (phase == PH_SKIP) ? 3'd1 :
            (phase == PH_WAKE) ? 3'd2 : 3'(INTRO_WAIT_TICKS);
    tick = wait_timer + 3'd1;

    if (item.kind == KIND_START) begin
      phase_next          = PH_SKIP;
      retry_count_next    = '0;
      wait_timer_next     = '0;
      ftsc_hits_next      = '0;
      yoohoo_hits_next    = '0;
      after_star_next     = 1'b0;
      match_position_next = '0;
      match_still_ok_next = 1'b1;
      crc_flag_next       = 1'b0;
      outcome_next        = ST_DETECT;
    end else if (phase == PH_SKIP || phase == PH_WAKE || phase == PH_WAIT) begin
      case (item.kind)
        KIND_ERROR: begin
          outcome_next = ST_FAIL;
          phase_next   = PH_DONE;
        end
        KIND_BYTE: begin
          wait_timer_next = '0;
          if (phase != PH_SKIP) begin
            if (phase == PH_WAKE) retry_count_next = '0;
            phase_next = PH_WAIT;
            if (c == CH_C) begin
              crc_flag_next  = 1'b1;
              ftsc_hits_next = ftsc_hits_next + 2'd1;
            end
            if (c == CH_NAK) begin
              crc_flag_next  = 1'b0;
              ftsc_hits_next = ftsc_hits_next + 2'd1;
            end
            if (c == CH_ENQ) yoohoo_hits_next = yoohoo_hits_next + 8'd1;
            if (!cfg.no_wazoo && yoohoo_hits_next > 8'd1) begin
              outcome_next = ST_YOOHOO;
              phase_next   = PH_DONE;
            end else if (ftsc_hits_next > 2'd1) begin
              outcome_next = ST_FTSC;
              phase_next   = PH_DONE;
            end else if (c >= 8'h20 && c <= 8'h7E) begin
              if (c != CH_C) ftsc_hits_next = '0;
              yoohoo_hits_next = '0;
              if (c == CH_STAR) begin
                after_star_next     = 1'b1;
                match_position_next = '0;
                match_still_ok_next = 1'b1;
              end else if (after_star) begin
                if (upcase(c) != req_char(match_position)) match_still_ok_next = 1'b0;
                match_position_next = match_position + 4'd1;
                if (match_position_next >= 4'd12) begin
                  hit = !cfg.no_emsi && match_still_ok_next;
                  after_star_next     = 1'b0;
                  match_position_next = '0;
                  match_still_ok_next = 1'b1;
                  if (hit) begin
                    cmd          = CMD_ANSWER;
                    outcome_next = ST_EMSI;
                    phase_next   = PH_DONE;
                  end
                end
              end
            end else if (c != CH_DC1) begin
              after_star_next     = 1'b0;
              match_position_next = '0;
              match_still_ok_next = 1'b1;
            end
          end
        end
        KIND_TICK: begin
          wait_timer_next = tick;
          if (tick >= limit) begin
            if (phase == PH_WAIT) begin
              after_star_next     = 1'b0;
              match_position_next = '0;
              match_still_ok_next = 1'b1;
              if (retry_count > 5'(MAX_INQUIRY_TRIES)) begin
                outcome_next = ST_FAIL;
                phase_next   = PH_DONE;
              end else begin
                retry_count_next = retry_count + 5'd1;
                cmd              = CMD_INTRO;
                wait_timer_next  = '0;
                phase_next       = PH_WAIT;
              end
            end else begin
              if (retry_count > 5'(MAX_WAKE_TRIES)) begin
                outcome_next = ST_FAIL;
                phase_next   = PH_DONE;
              end else begin
                retry_count_next = retry_count + 5'd1;
                cmd              = CMD_CR;
                wait_timer_next  = '0;
                phase_next       = PH_WAKE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign entry = '{cmd: cmd, status: outcome_next, crc: crc_flag_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      retry_count    <= '0;
      wait_timer     <= '0;
      ftsc_hits      <= '0;
      yoohoo_hits    <= '0;
      after_star     <= 1'b0;
      match_position <= '0;
      match_still_ok <= 1'b1;
      crc_flag       <= 1'b0;
      outcome        <= ST_IDLE;
    end else if (take) begin
      phase          <= phase_next;
      retry_count    <= retry_count_next;
      wait_timer     <= wait_timer_next;
      ftsc_hits      <= ftsc_hits_next;
      yoohoo_hits    <= yoohoo_hits_next;
      after_star     <= after_star_next;
      match_position <= match_position_next;
      match_still_ok <= match_still_ok_next;
      crc_flag       <= crc_flag_next;
      outcome        <= outcome_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/csd_queue.sv
// Command queue between the front and back ends.
`default_nettype none
module csd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire csd_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output csd_pkg::entry_t      head,
  output logic                 empty
);
  import csd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/csd_back.sv
// Back end: expands queued commands into transmit bytes, one result per cycle unless result_stall is set.
`default_nettype none
module csd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire csd_pkg::cfg_t   cfg,
  input  wire csd_pkg::entry_t head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output csd_pkg::result_t     result
);
  import csd_pkg::*;

  logic       active;
  entry_t     cur;
  logic [5:0] cur_idx;

  entry_t     sel;
  logic [5:0] sel_idx;
  logic [5:0] len;
  logic [7:0] tx_byte;
  logic       have, advance, is_last;

  assign advance = !result_valid || !result_stall;
  assign have    = active || !empty;
  assign pop     = advance && !active && !empty;
  assign sel     = active ? cur : head;
  assign sel_idx = active ? cur_idx : '0;

  always_comb begin
    logic       emsi, waz;
    logic [5:0] j;
    emsi = !cfg.no_emsi;
    waz  = !cfg.no_wazoo;
    j    = sel_idx - 6'd1 - (emsi ? BURST_LEN : 6'd0);
    case (sel.cmd)
      CMD_ANSWER: begin
        len     = ANSWER_LEN;
        tx_byte = answer_byte(sel_idx);
      end
      CMD_INTRO: begin
        len = 6'd2 + (emsi ? BURST_LEN + 6'd2 : 6'd0) + 6'(waz);
        if (sel_idx == 6'd0) begin
          tx_byte = CH_DC1;
        end else if (emsi && sel_idx <= BURST_LEN) begin
          tx_byte = burst_byte(sel_idx - 6'd1);
        end else begin
          // tail: [yoohoo] tsync [CR DC1]
          case (j)
            6'd0:    tx_byte = waz ? cfg.yoohoo_code : cfg.tsync_code;
            6'd1:    tx_byte = waz ? cfg.tsync_code : CH_CR;
            6'd2:    tx_byte = waz ? CH_CR : CH_DC1;
            default: tx_byte = CH_DC1;
          endcase
        end
      end
      CMD_CR: begin
        len     = 6'd1;
        tx_byte = CH_CR;
      end
      default: begin
        len     = 6'd1;
        tx_byte = 8'h00;
      end
    endcase
  end

  assign is_last = (sel_idx == len - 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      active       <= 1'b0;
    end else if (advance) begin
      result_valid <= have;
      if (have) active <= !is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && have) begin
      cur              <= sel;
      cur_idx          <= sel_idx + 6'd1;
      result.tx_valid  <= (sel.cmd != CMD_NONE);
      result.tx_byte   <= tx_byte;
      result.status    <= sel.status;
      result.crc_mode  <= sel.crc;
      result.last      <= is_last;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/caller_session_type_detector_unit.sv
// Top level of the caller-side session type detector.
`default_nettype none
// The front end takes one input transaction per cycle while the queue is not full and
// decides it at once; each transaction yields one command in a four-entry queue. The
// back end turns a command into results at one per cycle while result_stall is low: one
// result when nothing is sent, otherwise one per transmitted byte (1 for a wake CR, up to
// 34 for the inquiry burst, 31 for the EMSI answer). The input stalls only when the queue
// is full, which happens while long bursts drain. Configuration registers are written
// through wr_en/wr_index/wr_data and must be written only while the block is idle; no
// reset clearing pass is needed.
module caller_session_type_detector_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire csd_pkg::item_t    item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output csd_pkg::result_t       result,
  input  wire logic              wr_en,
  input  wire logic [1:0]        wr_index,
  input  wire logic [7:0]        wr_data
);
  import csd_pkg::*;

  cfg_t   cfg;
  entry_t entry, head;
  logic   full, empty, pop, take;

  assign item_stall = full;
  assign take       = item_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_emsi     <= 1'b0;
      cfg.no_wazoo    <= 1'b0;
      cfg.yoohoo_code <= 8'd241;
      cfg.tsync_code  <= 8'd174;
    end else if (wr_en) begin
      case (wr_index)
        REG_NO_EMSI:     cfg.no_emsi     <= wr_data[0];
        REG_NO_WAZOO:    cfg.no_wazoo    <= wr_data[0];
        REG_YOOHOO_CODE: cfg.yoohoo_code <= wr_data;
        REG_TSYNC_CODE:  cfg.tsync_code  <= wr_data;
        default: begin
        end
      endcase
    end
  end

  csd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .take  (take),
    .item  (item),
    .entry (entry)
  );

  csd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  csd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire
